// ===== sv/bmp_stream_to_bgra_top_defines.svh =====
// ---------------------------------------------------------------------------
// BMP stream decoder assertion macros
// Shared assertion forms, clocked on aclk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef BMP_STREAM_TO_BGRA_TOP_DEFINES_SVH
`define BMP_STREAM_TO_BGRA_TOP_DEFINES_SVH

// An implication or expression that must hold at every clock edge.
`define BSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// A condition that must never be seen at a clock edge.
`define BSB_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

// ===== sv/bsb_pkg.sv =====
// ---------------------------------------------------------------------------
// BMP stream decoder package
// Types, codes and constants shared by the decoder modules.
// ---------------------------------------------------------------------------
package bsb_pkg;

    localparam logic [31:0] MAX_WIDTH  = 32'd4096;
    localparam logic [31:0] MAX_HEIGHT = 32'd4096;
    localparam logic [31:0] HDR_LEN    = 32'd54;
    localparam logic [31:0] HDR_LAST   = 32'd53;

    localparam logic [7:0]  SIG_B      = 8'h42;
    localparam logic [7:0]  SIG_M      = 8'h4D;
    localparam logic [7:0]  OPAQUE     = 8'hFF;

    localparam logic [15:0] BPP_24     = 16'd24;
    localparam logic [15:0] BPP_32     = 16'd32;
    localparam logic [31:0] COMP_RGB   = 32'd0;
    localparam logic [31:0] COMP_BITF  = 32'd3;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int ROWSZ_W = 15;
    localparam int NEED_W  = ROWSZ_W + DIM_W;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_ERROR = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_SHORT = 3'd1,
        ERR_SIG   = 3'd2,
        ERR_FMT   = 3'd3,
        ERR_DIM   = 3'd4,
        ERR_TRUNC = 3'd5,
        ERR_SIZE  = 3'd6
    } err_code_t;

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           blue;
        logic [7:0]           green;
        logic [7:0]           red;
        logic [7:0]           alpha;
        logic [COORD_W-1:0]   column;
        logic [COORD_W-1:0]   row;
        err_code_t            error_code;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] bpp;
    } hdr_fields_t;

    typedef struct packed {
        logic [31:0]       hmag;
        logic [NEED_W-1:0] need;
        logic [1:0]        pad;
    } geom_t;

endpackage

// ===== sv/bsb_geom.sv =====
// ---------------------------------------------------------------------------
// BMP stream decoder geometry
// Registered height magnitude, row size, pixel data size and row padding,
// derived from the captured header fields.
// ---------------------------------------------------------------------------
module bsb_geom (
    input  logic                aclk,
    input  bsb_pkg::hdr_fields_t hdr,
    output bsb_pkg::geom_t      geom
);

    logic [31:0]                   hmag_reg, hmag_next;
    logic [bsb_pkg::ROWSZ_W-1:0]   row_size_reg, row_size_next;
    logic [bsb_pkg::NEED_W-1:0]    need_reg, need_next;
    logic [1:0]                    pad_reg, pad_next;
    logic [bsb_pkg::ROWSZ_W-1:0]   w15;
    logic [bsb_pkg::ROWSZ_W-1:0]   rs24;

    always_comb begin
        w15       = {2'b00, hdr.width[bsb_pkg::DIM_W-1:0]};
        rs24      = (w15 + (w15 << 1) + 15'd3) & ~15'd3;
        hmag_next = hdr.height[31] ? (32'd0 - hdr.height) : hdr.height;
        if (hdr.bpp == bsb_pkg::BPP_32) begin
            row_size_next = w15 << 2;
            pad_next      = 2'd0;
        end else begin
            row_size_next = rs24;
            pad_next      = hdr.width[1:0];
        end
        need_next = bsb_pkg::NEED_W'(row_size_reg * hmag_reg[bsb_pkg::DIM_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        hmag_reg     <= hmag_next;
        row_size_reg <= row_size_next;
        need_reg     <= need_next;
        pad_reg      <= pad_next;
    end

    assign geom.hmag = hmag_reg;
    assign geom.need = need_reg;
    assign geom.pad  = pad_reg;

endmodule

// ===== sv/bsb_parser.sv =====
// ---------------------------------------------------------------------------
// BMP stream decoder parser
// Header capture and checks, offset and padding skip, pixel assembly.
// Produces at most one result word per processed byte.
// ---------------------------------------------------------------------------
`include "bmp_stream_to_bgra_top_defines.svh"

module bsb_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  logic [7:0]           item_byte,
    input  logic                 item_sof,
    input  logic [31:0]          file_length,
    input  bsb_pkg::geom_t       geom,
    output bsb_pkg::hdr_fields_t hdr,
    output bsb_pkg::res_t        res,
    output logic                 res_valid
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_BODY,
        PH_DONE
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [31:0]                    pos_reg, pos_next;
    logic [31:0]                    offset_reg, offset_next;
    logic [31:0]                    width_reg, width_next;
    logic [31:0]                    height_reg, height_next;
    logic [15:0]                    planes_reg, planes_next;
    logic [15:0]                    bpp_reg, bpp_next;
    logic [31:0]                    comp_reg, comp_next;
    logic [23:0]                    pix_reg, pix_next;
    logic [1:0]                     bip_reg, bip_next;
    logic [bsb_pkg::COORD_W-1:0]    col_reg, col_next;
    logic [bsb_pkg::COORD_W-1:0]    srow_reg, srow_next;
    logic [1:0]                     pad_reg, pad_next;

    logic [31:0]                    pos;
    logic [1:0]                     lane;
    bsb_pkg::err_code_t             hdr_code;
    logic [32:0]                    need_total;
    logic [bsb_pkg::DIM_W-1:0]      hm13;
    logic [bsb_pkg::DIM_W-1:0]      flip_row;
    logic                           col_end;
    logic                           row_end;
    logic                           more_bytes;

    function automatic logic [31:0] put32(input logic [31:0] v, input logic [7:0] b,
                                          input logic [1:0] ln);
        logic [31:0] r;
        r = v;
        r[{ln, 3'b000} +: 8] = b;
        return r;
    endfunction

    function automatic logic [15:0] put16(input logic [15:0] v, input logic [7:0] b,
                                          input logic ln);
        logic [15:0] r;
        r = v;
        r[{ln, 3'b000} +: 8] = b;
        return r;
    endfunction

    assign hdr.width  = width_reg;
    assign hdr.height = height_reg;
    assign hdr.bpp    = bpp_reg;

    always_comb begin
        need_total = {1'b0, offset_next} + {5'b0, geom.need};
        if ((comp_next != bsb_pkg::COMP_RGB && comp_next != bsb_pkg::COMP_BITF) ||
            planes_next != 16'd1 ||
            (bpp_next != bsb_pkg::BPP_24 && bpp_next != bsb_pkg::BPP_32)) begin
            hdr_code = bsb_pkg::ERR_FMT;
        end else if (width_next[31] || width_next == 32'd0 || height_next == 32'd0) begin
            hdr_code = bsb_pkg::ERR_DIM;
        end else if (width_next > bsb_pkg::MAX_WIDTH || geom.hmag > bsb_pkg::MAX_HEIGHT ||
                     offset_next < bsb_pkg::HDR_LEN) begin
            hdr_code = bsb_pkg::ERR_SIZE;
        end else if (need_total > {1'b0, file_length}) begin
            hdr_code = bsb_pkg::ERR_TRUNC;
        end else begin
            hdr_code = bsb_pkg::ERR_NONE;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        planes_next = planes_reg;
        bpp_next    = bpp_reg;
        comp_next   = comp_reg;
        pix_next    = pix_reg;
        bip_next    = bip_reg;
        col_next    = col_reg;
        srow_next   = srow_reg;
        pad_next    = pad_reg;
        res         = '0;
        res_valid   = 1'b0;

        if (item_valid && item_sof) begin
            phase_next  = PH_HEADER;
            pos_next    = 32'd0;
            offset_next = 32'd0;
            width_next  = 32'd0;
            height_next = 32'd0;
            planes_next = 16'd0;
            bpp_next    = 16'd0;
            comp_next   = 32'd0;
            pix_next    = 24'd0;
            bip_next    = 2'd0;
            col_next    = '0;
            srow_next   = '0;
            pad_next    = 2'd0;
        end

        pos        = pos_next;
        lane       = pos[1:0] - 2'd2;
        hm13       = geom.hmag[bsb_pkg::DIM_W-1:0];
        flip_row   = hm13 - 13'd1 - {1'b0, srow_next};
        col_end    = ({1'b0, col_next} + 13'd1) == width_next[bsb_pkg::DIM_W-1:0];
        row_end    = ({1'b0, srow_next} + 13'd1) == hm13;
        more_bytes = (bpp_next == bsb_pkg::BPP_32) ? (bip_next != 2'd3) : (bip_next < 2'd2);

        if (item_valid && (phase_next == PH_HEADER || phase_next == PH_BODY)) begin
            pos_next = pos + 32'd1;
            if (phase_next == PH_HEADER) begin
                if (pos == 32'd0 && file_length < bsb_pkg::HDR_LEN) begin
                    res.kind       = bsb_pkg::KIND_ERROR;
                    res.error_code = bsb_pkg::ERR_SHORT;
                    res.last       = 1'b1;
                    res_valid      = 1'b1;
                    phase_next     = PH_DONE;
                end else if ((pos == 32'd0 && item_byte != bsb_pkg::SIG_B) ||
                             (pos == 32'd1 && item_byte != bsb_pkg::SIG_M)) begin
                    res.kind       = bsb_pkg::KIND_ERROR;
                    res.error_code = bsb_pkg::ERR_SIG;
                    res.last       = 1'b1;
                    res_valid      = 1'b1;
                    phase_next     = PH_DONE;
                end else begin
                    if (pos >= 32'd10 && pos <= 32'd13) begin
                        offset_next = put32(offset_next, item_byte, lane);
                    end else if (pos >= 32'd18 && pos <= 32'd21) begin
                        width_next = put32(width_next, item_byte, lane);
                    end else if (pos >= 32'd22 && pos <= 32'd25) begin
                        height_next = put32(height_next, item_byte, lane);
                    end else if (pos >= 32'd26 && pos <= 32'd27) begin
                        planes_next = put16(planes_next, item_byte, pos[0]);
                    end else if (pos >= 32'd28 && pos <= 32'd29) begin
                        bpp_next = put16(bpp_next, item_byte, pos[0]);
                    end else if (pos >= 32'd30 && pos <= 32'd33) begin
                        comp_next = put32(comp_next, item_byte, lane);
                    end
                    if (pos == bsb_pkg::HDR_LAST) begin
                        if (hdr_code != bsb_pkg::ERR_NONE) begin
                            res.kind       = bsb_pkg::KIND_ERROR;
                            res.error_code = hdr_code;
                            res.last       = 1'b1;
                            res_valid      = 1'b1;
                            phase_next     = PH_DONE;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                end
            end else if (pos >= offset_next) begin
                if (pad_next != 2'd0) begin
                    pad_next = pad_next - 2'd1;
                end else if (more_bytes) begin
                    pix_next[{bip_next, 3'b000} +: 8] = item_byte;
                    bip_next = bip_next + 2'd1;
                end else begin
                    res.kind   = bsb_pkg::KIND_PIXEL;
                    res.blue   = pix_next[7:0];
                    res.green  = pix_next[15:8];
                    if (bpp_next == bsb_pkg::BPP_32) begin
                        res.red   = pix_next[23:16];
                        res.alpha = item_byte;
                    end else begin
                        res.red   = item_byte;
                        res.alpha = bsb_pkg::OPAQUE;
                    end
                    res.column     = col_next;
                    res.row        = height_next[31] ? srow_next
                                                     : flip_row[bsb_pkg::COORD_W-1:0];
                    res.error_code = bsb_pkg::ERR_NONE;
                    res.last       = col_end && row_end;
                    res_valid      = 1'b1;
                    pix_next       = 24'd0;
                    bip_next       = 2'd0;
                    if (col_end) begin
                        col_next  = '0;
                        srow_next = srow_next + 12'd1;
                        pad_next  = geom.pad;
                    end else begin
                        col_next = col_next + 12'd1;
                    end
                    if (col_end && row_end) begin
                        phase_next = PH_DONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT;
            pos_reg    <= 32'd0;
            offset_reg <= 32'd0;
            width_reg  <= 32'd0;
            height_reg <= 32'd0;
            planes_reg <= 16'd0;
            bpp_reg    <= 16'd0;
            comp_reg   <= 32'd0;
            pix_reg    <= 24'd0;
            bip_reg    <= 2'd0;
            col_reg    <= '0;
            srow_reg   <= '0;
            pad_reg    <= 2'd0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            planes_reg <= planes_next;
            bpp_reg    <= bpp_next;
            comp_reg   <= comp_next;
            pix_reg    <= pix_next;
            bip_reg    <= bip_next;
            col_reg    <= col_next;
            srow_reg   <= srow_next;
            pad_reg    <= pad_next;
        end
    end

    `BSB_ASSERT(a_err_last, res_valid && res.kind == bsb_pkg::KIND_ERROR |-> res.last, "error word without last")
    `BSB_ASSERT(a_body_offset, phase_reg == PH_BODY |-> offset_reg >= bsb_pkg::HDR_LEN, "body entered with a bad pixel offset")
    `BSB_ASSERT(a_idle_quiet, item_valid && !item_sof && (phase_reg == PH_WAIT || phase_reg == PH_DONE) |-> !res_valid, "word produced while not parsing")

endmodule

// ===== sv/bsb_out_buf.sv =====
// ---------------------------------------------------------------------------
// BMP stream decoder output buffer
// Result register with a skid entry, so the parser keeps running for one
// word after the receiver stalls.
// ---------------------------------------------------------------------------
`include "bmp_stream_to_bgra_top_defines.svh"

module bsb_out_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bsb_pkg::res_t push_data,
    output logic          space,
    output logic          m_valid,
    input  logic          m_ready,
    output bsb_pkg::res_t m_data
);

    logic          main_valid_reg, main_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    bsb_pkg::res_t main_reg, main_next;
    bsb_pkg::res_t skid_reg, skid_next;
    logic          pop;

    assign pop     = main_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `BSB_ASSERT_NEVER(a_skid_alone, skid_valid_reg && !main_valid_reg, "skid entry held behind an empty result register")
    `BSB_ASSERT_NEVER(a_no_overflow, push && skid_valid_reg, "word pushed into a full buffer")
    `BSB_ASSERT(a_skid_drain, main_valid_reg && skid_valid_reg && m_ready |=> main_valid_reg && !skid_valid_reg, "skid entry not moved forward")

endmodule

// ===== sv/bmp_stream_to_bgra_top.sv =====
// ---------------------------------------------------------------------------
// BMP stream to BGRA decoder, top level
// Streams a 24 or 32 bpp BMP file one byte per word and returns one word
// per pixel with destination coordinates, or one coded error word.
// ---------------------------------------------------------------------------
// Usage: write the file length on the cfg channel while the block is idle,
// then stream the file bytes on the s_ channel with s_start_of_file set on
// the first byte. A set start_of_file restarts the parse at any time.
// The m_ channel returns a word for every complete pixel, top-down row
// numbering, with m_last on the final pixel; a bad header gives a single
// error word with m_last set, and the rest of the file is dropped.
// Path: a byte accepted on s_ is held in the input register, parsed once the
// output buffer has space, and its word is registered before m_valid shows it.
// Throughput: one byte per cycle while the skid entry is empty, set by the
// input register and the combinational parse that feeds the result register.
// Stall: a result register plus one skid entry buffer the output; while the
// skid entry is full, parsing pauses and s_ready drops once the input
// register is also full. s_ready does not depend on m_ready in the same cycle.
// Reset (aresetn low at a clock edge) empties both stages, clears the file
// length and leaves the parser waiting for a start-of-file byte.
// ---------------------------------------------------------------------------
module bmp_stream_to_bgra_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_file_length,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_green,
    output logic [7:0]  m_red,
    output logic [7:0]  m_alpha,
    output logic [11:0] m_column,
    output logic [11:0] m_row,
    output logic [2:0]  m_error_code,
    output logic        m_last
);

    logic                 file_length_reg, unused_dummy;
    logic [31:0]          flen_reg, flen_next;
    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg, in_byte_next;
    logic                 in_sof_reg, in_sof_next;
    logic                 proc_fire;
    logic                 space;
    logic                 res_valid;
    bsb_pkg::res_t        res;
    bsb_pkg::res_t        m_res;
    bsb_pkg::hdr_fields_t hdr;
    bsb_pkg::geom_t       geom;

    assign file_length_reg = 1'b0;
    assign unused_dummy    = file_length_reg;

    assign cfg_ready = 1'b1;
    assign proc_fire = in_valid_reg && space;
    assign s_ready   = !in_valid_reg || proc_fire;

    always_comb begin
        flen_next     = flen_reg;
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_sof_next   = in_sof_reg;
        if (cfg_valid && cfg_ready) begin
            flen_next = cfg_file_length;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_file_byte;
            in_sof_next   = s_start_of_file;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flen_reg     <= 32'd0;
            in_valid_reg <= 1'b0;
        end else begin
            flen_reg     <= flen_next;
            in_valid_reg <= in_valid_next;
        end
        in_byte_reg <= in_byte_next;
        in_sof_reg  <= in_sof_next;
    end

    bsb_geom u_geom (
        .aclk (aclk),
        .hdr  (hdr),
        .geom (geom)
    );

    bsb_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (proc_fire),
        .item_byte   (in_byte_reg),
        .item_sof    (in_sof_reg),
        .file_length (flen_reg),
        .geom        (geom),
        .hdr         (hdr),
        .res         (res),
        .res_valid   (res_valid)
    );

    bsb_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_res)
    );

    assign m_result_kind = m_res.kind;
    assign m_blue        = m_res.blue;
    assign m_green       = m_res.green;
    assign m_red         = m_res.red;
    assign m_alpha       = m_res.alpha;
    assign m_column      = m_res.column;
    assign m_row         = m_res.row;
    assign m_error_code  = m_res.error_code;
    assign m_last        = m_res.last;

endmodule
